// ----- rtl/core/bvpp_pkg.sv -----
// shared types and constants of the buck voltage pid and pwm block
package bvpp_pkg;

   localparam int ADC_BITS  = 12;
   localparam int FRAC_BITS = 16;

   // field and register widths
   localparam int GAIN_W     = 24;
   localparam int VOLT_W     = 24;
   localparam int DUTY_W     = 23;
   localparam int PERIOD_W   = 32;
   localparam int ERR_W      = VOLT_W + 1;
   localparam int COEF_W     = GAIN_W + 2;
   localparam int DRIVE_W    = 40;
   localparam int ACC_W      = 53;
   localparam int VREF_W     = 18;
   localparam int MEAS_RAW_W = VOLT_W + 2;

   // shared multiplier operands and product
   localparam int MUL_A_W = PERIOD_W + 1;
   localparam int MUL_B_W = COEF_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // compare value: ((period+1)*duty >> (FRAC_BITS+2))/25 - 1, byte per step
   localparam int CMP_PROD_W = PERIOD_W + DUTY_W + 1;
   localparam int DIV_SHIFT  = FRAC_BITS + 2;
   localparam int DIV_CONST  = 25;
   localparam int DIV_REM_W  = 5;
   localparam int DIGIT_W    = 8;
   localparam int DIV_DIGITS = 5;
   localparam int DIV_W      = DIGIT_W * DIV_DIGITS;
   localparam int DIV_CNT_W  = 3;
   localparam int DIV_V_W    = DIV_REM_W + DIGIT_W;

   localparam logic [VREF_W-1:0] VREF_Q = VREF_W'(((33 << FRAC_BITS) + 5) / 10);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIVIDER    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEBUG_EN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEBUG_DUTY = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD     = 3'd7;

   localparam logic [GAIN_W-1:0]   RST_GAIN_P     = 24'd32768;
   localparam logic [GAIN_W-1:0]   RST_GAIN_I     = 24'd328;
   localparam logic [GAIN_W-1:0]   RST_GAIN_D     = 24'd0;
   localparam logic [VOLT_W-1:0]   RST_SETPOINT   = 24'd0;
   localparam logic [VOLT_W-1:0]   RST_DIVIDER    = 24'd776667;
   localparam logic [DUTY_W-1:0]   RST_DEBUG_DUTY = 23'd3276800;
   localparam logic [PERIOD_W-1:0] RST_PERIOD     = 32'd0;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d;
      logic [VOLT_W-1:0]   setpoint_volts;
      logic [VOLT_W-1:0]   divider_ratio;
      logic                debug_enable;
      logic [DUTY_W-1:0]   debug_duty_pct;
      logic [PERIOD_W-1:0] timer_period;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_ADC,
      MUL_MEAS,
      MUL_E0,
      MUL_E1,
      MUL_E2,
      MUL_CMP
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        meas_ld;
      logic        acc_clr;
      logic        acc_add;
      logic        drive_ld;
      logic        duty_ld;
      logic        div_load;
      logic        div_step;
      logic        out_ld;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_ADC,
      ST_MUL_MEAS,
      ST_ERR,
      ST_MUL_E0,
      ST_MUL_E1,
      ST_MUL_E2,
      ST_ACC,
      ST_DRIVE,
      ST_DUTY,
      ST_MUL_CMP,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/core/bvpp_regs.sv -----
// configuration register file of the buck voltage pid and pwm block
module bvpp_regs import bvpp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GAIN_P:     cfg_in.gain_p         = csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i         = csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d         = csr_wdata[GAIN_W-1:0];
            REG_SETPOINT:   cfg_in.setpoint_volts = csr_wdata[VOLT_W-1:0];
            REG_DIVIDER:    cfg_in.divider_ratio  = csr_wdata[VOLT_W-1:0];
            REG_DEBUG_EN:   cfg_in.debug_enable   = csr_wdata[0];
            REG_DEBUG_DUTY: cfg_in.debug_duty_pct = csr_wdata[DUTY_W-1:0];
            REG_PERIOD:     cfg_in.timer_period   = csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= RST_GAIN_P;
         cfg_ff.gain_i         <= RST_GAIN_I;
         cfg_ff.gain_d         <= RST_GAIN_D;
         cfg_ff.setpoint_volts <= RST_SETPOINT;
         cfg_ff.divider_ratio  <= RST_DIVIDER;
         cfg_ff.debug_enable   <= 1'b0;
         cfg_ff.debug_duty_pct <= RST_DEBUG_DUTY;
         cfg_ff.timer_period   <= RST_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/bvpp_dpath.sv -----
// datapath: shared multiplier, pid history, duty clamp and byte-serial divide by 25
module bvpp_dpath import bvpp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [ADC_BITS-1:0] sample,
   output logic [VOLT_W-1:0]   measured_volts,
   output logic [DUTY_W-1:0]   duty_pct,
   output logic [PERIOD_W-1:0] compare_value
);

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};
   localparam logic signed [DRIVE_W-1:0] DUTY_MAX_Q = DRIVE_W'(95 * (1 << FRAC_BITS));
   localparam logic signed [DRIVE_W-1:0] DUTY_MIN_Q = DRIVE_W'(1 << FRAC_BITS);
   localparam logic [DIV_V_W-1:0]        DIV_DVSR   = DIV_V_W'(DIV_CONST);

   // working registers
   logic [ADC_BITS-1:0]       sample_ff;
   logic signed [COEF_W-1:0]  a0_ff, a1_ff, a2_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [VOLT_W-1:0]         meas_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DRIVE_W-1:0] u_ff;
   logic [DUTY_W-1:0]         duty_ff;
   logic [DIV_W-1:0]          divx_ff;
   logic [DIV_REM_W-1:0]      rem_ff;
   logic [DIV_W-1:0]          quo_ff;
   logic [DIV_CNT_W-1:0]      cnt_ff;

   // pid history
   logic signed [ERR_W-1:0]   e1_ff, e2_ff;
   logic signed [DRIVE_W-1:0] drive_ff;

   // result word
   logic [VOLT_W-1:0]   meas_out_ff;
   logic [DUTY_W-1:0]   duty_out_ff;
   logic [PERIOD_W-1:0] cmp_out_ff;

   logic signed [COEF_W-1:0]  kp_ext, ki_ext, kd_ext;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_out;
   logic [MEAS_RAW_W-1:0]     meas_raw;
   logic [VOLT_W-1:0]         meas_sat;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [DRIVE_W:0]   u_sum;
   logic signed [DRIVE_W-1:0] u_sat;
   logic [DUTY_W-1:0]         duty_in;
   logic [CMP_PROD_W-1:0]     cmp_prod;
   logic [DIV_V_W-1:0]        div_v;
   logic [DIGIT_W-1:0]        div_q;
   logic [DIV_W-1:0]          quo_m1;
   logic [PERIOD_W-1:0]       cmp_in;

   assign kp_ext = {{(COEF_W-GAIN_W){cfg.gain_p[GAIN_W-1]}}, cfg.gain_p};
   assign ki_ext = {{(COEF_W-GAIN_W){cfg.gain_i[GAIN_W-1]}}, cfg.gain_i};
   assign kd_ext = {{(COEF_W-GAIN_W){cfg.gain_d[GAIN_W-1]}}, cfg.gain_d};

   // operand select for the one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_ADC: begin
            mul_a = MUL_A_W'(sample_ff);
            mul_b = MUL_B_W'(VREF_Q);
         end
         MUL_MEAS: begin
            mul_a = MUL_A_W'(cfg.divider_ratio);
            mul_b = MUL_B_W'(prod_ff[ADC_BITS+VREF_W-1:ADC_BITS]);
         end
         MUL_E0: begin
            mul_a = {{(MUL_A_W-COEF_W){a0_ff[COEF_W-1]}}, a0_ff};
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         MUL_E1: begin
            mul_a = {{(MUL_A_W-COEF_W){a1_ff[COEF_W-1]}}, a1_ff};
            mul_b = {{(MUL_B_W-ERR_W){e1_ff[ERR_W-1]}}, e1_ff};
         end
         MUL_E2: begin
            mul_a = {{(MUL_A_W-COEF_W){a2_ff[COEF_W-1]}}, a2_ff};
            mul_b = {{(MUL_B_W-ERR_W){e2_ff[ERR_W-1]}}, e2_ff};
         end
         MUL_CMP: begin
            mul_a = MUL_A_W'(cfg.timer_period);
            mul_b = MUL_B_W'(duty_ff);
         end
         default: ;
      endcase
   end

   assign mul_out = mul_a * mul_b;

   // measured volts and error
   assign meas_raw = prod_ff[FRAC_BITS+MEAS_RAW_W-1:FRAC_BITS];
   assign meas_sat = (|meas_raw[MEAS_RAW_W-1:VOLT_W]) ? {VOLT_W{1'b1}}
                                                       : meas_raw[VOLT_W-1:0];
   assign err_in   = $signed({1'b0, cfg.setpoint_volts}) - $signed({1'b0, meas_sat});

   assign acc_in = (cmd.acc_clr ? '0 : acc_ff) + $signed(prod_ff[ACC_W-1:0]);

   // floored sum plus previous drive, saturated to the history width
   assign u_sum = {{(DRIVE_W+1-(ACC_W-FRAC_BITS)){acc_ff[ACC_W-1]}},
                   acc_ff[ACC_W-1:FRAC_BITS]}
                + {drive_ff[DRIVE_W-1], drive_ff};
   assign u_sat = (u_sum[DRIVE_W] != u_sum[DRIVE_W-1])
                ? (u_sum[DRIVE_W] ? DRIVE_MIN : DRIVE_MAX)
                : u_sum[DRIVE_W-1:0];

   always_comb begin
      if (cfg.debug_enable) begin
         duty_in = cfg.debug_duty_pct;
      end else if (u_ff > DUTY_MAX_Q) begin
         duty_in = DUTY_MAX_Q[DUTY_W-1:0];
      end else if (u_ff < DUTY_MIN_Q) begin
         duty_in = DUTY_MIN_Q[DUTY_W-1:0];
      end else begin
         duty_in = u_ff[DUTY_W-1:0];
      end
   end

   // (period+1)*duty as period*duty + duty
   assign cmp_prod = prod_ff[CMP_PROD_W-1:0] + CMP_PROD_W'(duty_ff);

   // one quotient byte: restoring steps against 25 shifted
   always_comb begin
      div_v = {rem_ff, divx_ff[DIV_W-1 -: DIGIT_W]};
      div_q = '0;
      for (int k = DIGIT_W - 1; k >= 0; k--) begin
         if (div_v >= (DIV_DVSR << k)) begin
            div_v    = div_v - (DIV_DVSR << k);
            div_q[k] = 1'b1;
         end
      end
   end

   assign quo_m1 = quo_ff - DIV_W'(1);
   always_comb begin
      if (quo_ff == '0) begin
         cmp_in = '0;
      end else if (|quo_m1[DIV_W-1:PERIOD_W]) begin
         cmp_in = {PERIOD_W{1'b1}};
      end else begin
         cmp_in = quo_m1[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sample_ff <= sample;
         a0_ff     <= kp_ext + ki_ext + kd_ext;
         a1_ff     <= -kp_ext - (kd_ext <<< 1);
         a2_ff     <= kd_ext;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_out;
      end
      if (cmd.meas_ld) begin
         meas_ff <= meas_sat;
         err_ff  <= err_in;
      end
      if (cmd.acc_clr || cmd.acc_add) begin
         acc_ff <= acc_in;
      end
      if (cmd.drive_ld) begin
         u_ff <= u_sat;
      end
      if (cmd.duty_ld) begin
         duty_ff <= duty_in;
      end
      if (cmd.div_load) begin
         divx_ff <= DIV_W'(cmp_prod[CMP_PROD_W-1:DIV_SHIFT]);
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         divx_ff <= divx_ff << DIGIT_W;
         rem_ff  <= div_v[DIV_REM_W-1:0];
         quo_ff  <= {quo_ff[DIV_W-DIGIT_W-1:0], div_q};
         cnt_ff  <= cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.out_ld) begin
         meas_out_ff <= meas_ff;
         duty_out_ff <= duty_ff;
         cmp_out_ff  <= cmp_in;
      end
   end

   // history moves only on a pid step outside debug mode
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff    <= '0;
         e2_ff    <= '0;
         drive_ff <= '0;
      end else if (cmd.drive_ld && !cfg.debug_enable) begin
         e2_ff    <= e1_ff;
         e1_ff    <= err_ff;
         drive_ff <= u_sat;
      end
   end

   assign stat.div_last  = (cnt_ff == DIV_CNT_W'(DIV_DIGITS - 1));
   assign measured_volts = meas_out_ff;
   assign duty_pct       = duty_out_ff;
   assign compare_value  = cmp_out_ff;

endmodule

// ----- rtl/core/bvpp_ctrl.sv -----
// controller: sequences the datapath steps and owns both handshakes
module bvpp_ctrl import bvpp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL_ADC;
            end
         end
         ST_MUL_ADC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ADC;
            state_in    = ST_MUL_MEAS;
         end
         ST_MUL_MEAS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MEAS;
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            cmd.meas_ld = 1'b1;
            state_in    = ST_MUL_E0;
         end
         ST_MUL_E0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_E0;
            state_in    = ST_MUL_E1;
         end
         ST_MUL_E1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_E1;
            cmd.acc_clr = 1'b1;
            state_in    = ST_MUL_E2;
         end
         ST_MUL_E2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_E2;
            cmd.acc_add = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_DRIVE;
         end
         ST_DRIVE: begin
            cmd.drive_ld = 1'b1;
            state_in     = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.duty_ld = 1'b1;
            state_in    = ST_MUL_CMP;
         end
         ST_MUL_CMP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CMP;
            state_in    = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait here only while the previous word is still unclaimed
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_ld) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL_ADC))
      else $error("accepted word did not start the sequence");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!out_valid_ff || rsp_tready))
      else $error("result register loaded over an unclaimed word");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && stat.div_last) |=> (state_ff == ST_FINISH))
      else $error("divide did not end after its last digit");

endmodule

// ----- rtl/core/buck_voltage_pid_pwm.sv -----
// top level of the buck voltage pid controller with pwm compare output
//
//   channel   dir   ports                        word
//   req       in    req_tvalid/tready/tdata      adc sample
//   rsp       out   rsp_tvalid/tready/tdata      measured volts, duty, compare value
//   csr       in    csr_wr_en/index/wdata        register write, no read-back
//
// a new word is taken only in idle, so each word runs through six products on the
// one shared 33x26 multiplier and a five-step byte-serial divide by 25.
// a finished result sits in the output register while the next word is accepted;
// the block waits before loading it only if the previous result is still unclaimed.
// synchronous active-high reset clears the sequencer, the pid history and the
// configuration registers to their reset values.
module buck_voltage_pid_pwm import bvpp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [11:0] adc_sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [79:0]           rsp_tdata,   // [23:0] measured_volts, [46:24] duty_pct,
                                              // [78:47] compare_value
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg;
   cmd_type             cmd;
   stat_type            stat;
   logic [VOLT_W-1:0]   measured_volts;
   logic [DUTY_W-1:0]   duty_pct;
   logic [PERIOD_W-1:0] compare_value;

   bvpp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bvpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bvpp_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .stat           (stat),
      .sample         (req_tdata[ADC_BITS-1:0]),
      .measured_volts (measured_volts),
      .duty_pct       (duty_pct),
      .compare_value  (compare_value)
   );

   assign rsp_tdata = {1'b0, compare_value, duty_pct, measured_volts};

endmodule
